// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; they compile to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("invariant violated");
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication violated");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");
`else
`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/fuh_pkg.sv =====
// ----------------------------------------------------------------------------
// fuh_pkg
// Types and constants shared by the firmware update request handler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fuh_pkg;

   localparam logic [7:0]  FC_FIRMWARE     = 8'h50;

   localparam logic [15:0] CMD_SYNC        = 16'd1;
   localparam logic [15:0] CMD_CHECK       = 16'd2;
   localparam logic [15:0] CMD_START       = 16'd3;
   localparam logic [15:0] CMD_WRITE       = 16'd4;
   localparam logic [15:0] CMD_UPDATE      = 16'd5;

   localparam logic [1:0]  SYNC_NEEDED     = 2'd3;
   localparam logic [15:0] HEADER_BYTES    = 16'd4;
   localparam logic [31:0] PARTITION_RESET = 32'd1048576;

   localparam logic [1:0]  PHASE_IDLE      = 2'd0;
   localparam logic [1:0]  PHASE_ERASED    = 2'd1;
   localparam logic [1:0]  PHASE_WRITING   = 2'd2;
   localparam logic [1:0]  PHASE_UPDATE    = 2'd3;

   localparam logic [2:0]  RSP_BYTES_SHORT = 3'd4;
   localparam logic [2:0]  RSP_BYTES_START = 3'd5;
   localparam logic [2:0]  RSP_BYTES_WRITE = 3'd7;

   localparam logic [15:0] REPLY_PLAIN     = 16'd0;
   localparam logic [15:0] REPLY_START     = 16'd1;
   localparam logic [15:0] REPLY_WRITE     = 16'd3;

   // Operation classes decided by the front end.
   localparam logic [2:0]  OP_NONE         = 3'd0;
   localparam logic [2:0]  OP_SYNC         = 3'd1;
   localparam logic [2:0]  OP_CHECK        = 3'd2;
   localparam logic [2:0]  OP_START        = 3'd3;
   localparam logic [2:0]  OP_START_BAD    = 3'd4;
   localparam logic [2:0]  OP_WRITE        = 3'd5;
   localparam logic [2:0]  OP_WRITE_BAD    = 3'd6;
   localparam logic [2:0]  OP_UPDATE       = 3'd7;

   typedef struct packed {
      logic [2:0]  op;
      logic [15:0] command;
      logic [31:0] image_length;
      logic [15:0] packet_number;
      logic [15:0] chunk_length;
      logic        flash_ok;
   } cls_type;

   typedef struct packed {
      logic        respond;
      logic        illegal_value;
      logic [2:0]  response_bytes;
      logic [15:0] echo_command;
      logic [15:0] reply_word;
      logic [15:0] reply_packet;
      logic        reply_status;
      logic        erase_request;
      logic        write_request;
      logic [31:0] write_offset;
      logic [15:0] write_length;
      logic        update_requested;
   } rsp_type;

endpackage

// ===== hdl/fuh_if.sv =====
// ----------------------------------------------------------------------------
// fuh_if
// Handshake channels of the request handler: requests, responses, register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fuh_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  function_code;
   logic [15:0] command;
   logic [15:0] data_length;
   logic [31:0] image_length;
   logic [15:0] packet_number;
   logic [15:0] chunk_length;
   logic        flash_ok;

   modport source (output valid, function_code, command, data_length, image_length,
                   packet_number, chunk_length, flash_ok, input ready);
   modport sink   (input valid, function_code, command, data_length, image_length,
                   packet_number, chunk_length, flash_ok, output ready);
endinterface

interface fuh_rsp_if;
   logic             valid;
   logic             ready;
   fuh_pkg::rsp_type payload;

   modport source (output valid, payload, input ready);
   modport sink   (input valid, payload, output ready);
endinterface

interface fuh_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ===== hdl/fuh_front.sv =====
// ----------------------------------------------------------------------------
// fuh_front
// Accepts request words, holds the partition size and classifies each request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fuh_front (
   input  logic             clock,
   input  logic             reset,
   fuh_req_if.sink          req_chan,
   fuh_csr_if.sink          csr_chan,
   input  logic             q_full,
   output logic             q_push,
   output fuh_pkg::cls_type q_data
);
   import fuh_pkg::*;

   logic [31:0] partition_ff;
   logic [31:0] partition_in;
   logic [16:0] expect_length;
   logic        start_bad;
   logic        write_bad;
   logic [2:0]  op;

   assign csr_chan.ready = 1'b1;
   assign partition_in   = csr_chan.valid ? csr_chan.data : partition_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         partition_ff <= PARTITION_RESET;
      end else begin
         partition_ff <= partition_in;
      end
   end

   // The header plus chunk sum is taken one bit wider so that it cannot wrap.
   assign expect_length = {1'b0, HEADER_BYTES} + {1'b0, req_chan.chunk_length};
   assign start_bad = (req_chan.data_length != HEADER_BYTES) ||
                      (req_chan.image_length > partition_ff);
   assign write_bad = (req_chan.data_length < HEADER_BYTES) ||
                      (req_chan.packet_number == 16'd0) ||
                      ({1'b0, req_chan.data_length} != expect_length);

   always_comb begin
      op = OP_NONE;
      if (req_chan.function_code == FC_FIRMWARE) begin
         unique case (req_chan.command)
            CMD_SYNC:   op = OP_SYNC;
            CMD_CHECK:  op = OP_CHECK;
            CMD_START:  op = start_bad ? OP_START_BAD : OP_START;
            CMD_WRITE:  op = write_bad ? OP_WRITE_BAD : OP_WRITE;
            CMD_UPDATE: op = OP_UPDATE;
            default:    op = OP_NONE;
         endcase
      end
   end

   assign req_chan.ready       = !q_full;
   assign q_push               = req_chan.valid && !q_full;
   assign q_data.op            = op;
   assign q_data.command       = req_chan.command;
   assign q_data.image_length  = req_chan.image_length;
   assign q_data.packet_number = req_chan.packet_number;
   assign q_data.chunk_length  = req_chan.chunk_length;
   assign q_data.flash_ok      = req_chan.flash_ok;

endmodule

// ===== hdl/fuh_queue.sv =====
// ----------------------------------------------------------------------------
// fuh_queue
// Short first-in first-out queue of classified requests between the two sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fuh_queue #(
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  fuh_pkg::cls_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             valid,
   output fuh_pkg::cls_type pop_data
);
   import fuh_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   cls_type          slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == FULL_COUNT);
   assign valid    = (count_ff != '0);
   assign pop_data = slots_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hdl/fuh_back.sv =====
// ----------------------------------------------------------------------------
// fuh_back
// Carries out classified requests against the loader state, one per cycle unless the response stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fuh_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  fuh_pkg::cls_type q_data,
   output logic             q_pop,
   fuh_rsp_if.source        rsp_chan
);
   import fuh_pkg::*;

   logic        unlocked_ff;
   logic        unlocked_in;
   logic [1:0]  sync_count_ff;
   logic [1:0]  sync_count_in;
   logic [1:0]  phase_ff;
   logic [1:0]  phase_in;
   logic [31:0] written_ff;
   logic [31:0] written_in;
   // Bytes of the image still to be written; zero means the image is complete.
   logic [31:0] remaining_ff;
   logic [31:0] remaining_in;
   logic [15:0] last_packet_ff;
   logic [15:0] last_packet_in;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   rsp_type     rsp_data_ff;
   rsp_type     rsp_data_in;
   rsp_type     result;
   logic        take;
   logic        allowed;
   logic        chunk_fits;
   logic [15:0] clip_length;

   assign take    = q_valid && (!rsp_valid_ff || rsp_chan.ready);
   assign q_pop   = take;
   assign allowed = (q_data.op == OP_SYNC) || ((q_data.op != OP_NONE) && unlocked_ff);

   assign chunk_fits  = (remaining_ff[31:16] != 16'd0) ||
                        (remaining_ff[15:0] >= q_data.chunk_length);
   assign clip_length = chunk_fits ? q_data.chunk_length : remaining_ff[15:0];

   always_comb begin
      result         = '0;
      unlocked_in    = unlocked_ff;
      sync_count_in  = sync_count_ff;
      phase_in       = phase_ff;
      written_in     = written_ff;
      remaining_in   = remaining_ff;
      last_packet_in = last_packet_ff;
      if (allowed) begin
         unique case (q_data.op)
            OP_SYNC: begin
               if (sync_count_ff != SYNC_NEEDED) begin
                  sync_count_in = sync_count_ff + 2'd1;
               end
               unlocked_in = unlocked_ff || (sync_count_in == SYNC_NEEDED);
            end
            OP_CHECK: begin
               result.respond        = 1'b1;
               result.response_bytes = RSP_BYTES_SHORT;
               result.echo_command   = q_data.command;
               result.reply_word     = REPLY_PLAIN;
            end
            OP_START_BAD, OP_WRITE_BAD: begin
               result.respond       = 1'b1;
               result.illegal_value = 1'b1;
            end
            OP_START: begin
               written_in            = '0;
               remaining_in          = q_data.image_length;
               last_packet_in        = '0;
               result.respond        = 1'b1;
               result.response_bytes = RSP_BYTES_START;
               result.echo_command   = q_data.command;
               result.reply_word     = REPLY_START;
               if (phase_ff == PHASE_ERASED) begin
                  result.reply_status = 1'b1;
               end else begin
                  result.erase_request = 1'b1;
                  result.reply_status  = q_data.flash_ok;
                  if (q_data.flash_ok) begin
                     phase_in = PHASE_ERASED;
                  end
               end
            end
            OP_WRITE: begin
               result.respond        = 1'b1;
               result.response_bytes = RSP_BYTES_WRITE;
               result.echo_command   = q_data.command;
               result.reply_word     = REPLY_WRITE;
               // Repeated packets are acknowledged, stale ones refused.
               priority if (q_data.packet_number == last_packet_ff) begin
                  result.reply_packet = last_packet_ff;
                  result.reply_status = 1'b1;
               end else if (q_data.packet_number < last_packet_ff) begin
                  result.reply_packet = last_packet_ff;
               end else begin
                  last_packet_in      = q_data.packet_number;
                  result.reply_packet = q_data.packet_number;
                  if (remaining_ff == 32'd0) begin
                     result.reply_status = 1'b1;
                  end else begin
                     phase_in             = PHASE_WRITING;
                     result.write_request = 1'b1;
                     result.write_offset  = written_ff;
                     result.write_length  = clip_length;
                     if (q_data.flash_ok) begin
                        written_in          = written_ff + {16'd0, clip_length};
                        remaining_in        = remaining_ff - {16'd0, clip_length};
                        result.reply_status = 1'b1;
                     end
                  end
               end
            end
            OP_UPDATE: begin
               phase_in                = PHASE_UPDATE;
               result.respond          = 1'b1;
               result.response_bytes   = RSP_BYTES_SHORT;
               result.echo_command     = q_data.command;
               result.reply_word       = REPLY_PLAIN;
               result.update_requested = 1'b1;
            end
            OP_NONE: begin
               result = '0;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unlocked_ff    <= 1'b0;
         sync_count_ff  <= '0;
         phase_ff       <= PHASE_IDLE;
         written_ff     <= '0;
         remaining_ff   <= '0;
         last_packet_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            unlocked_ff    <= unlocked_in;
            sync_count_ff  <= sync_count_in;
            phase_ff       <= phase_in;
            written_ff     <= written_in;
            remaining_ff   <= remaining_in;
            last_packet_ff <= last_packet_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

endmodule

// ===== hdl/firmware_update_request_handler.sv =====
// ----------------------------------------------------------------------------
// firmware_update_request_handler: in-application-programming request handler.
// A request word passes through a queue slot and then the response register.
// Throughput: one word per cycle; the back end retires one queue entry a cycle unless the response stalls.
// Reset is synchronous; loader state and queue clear at once, no sweep needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module firmware_update_request_handler #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic      clock,
   input  logic      reset,
   fuh_req_if.sink   req_chan,
   fuh_rsp_if.source rsp_chan,
   fuh_csr_if.sink   csr_chan
);
   import fuh_pkg::*;

   logic    q_full;
   logic    q_push;
   cls_type q_push_data;
   logic    q_pop;
   logic    q_valid;
   cls_type q_pop_data;

   fuh_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .csr_chan (csr_chan),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (q_push_data)
   );

   fuh_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_data  (q_pop_data)
   );

   fuh_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_data   (q_pop_data),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

   // An accepted request is always waiting in the queue on the next cycle.
   `ASSERT_NEXT(a_push_lands, clock, reset, req_chan.valid && req_chan.ready, q_valid)
   `ASSERT_ALWAYS(a_one_flash_op, clock, reset, !(rsp_chan.valid && rsp_chan.payload.erase_request && rsp_chan.payload.write_request))
   `ASSERT_IMPLY(a_write_reply, clock, reset, rsp_chan.valid && rsp_chan.payload.write_request, rsp_chan.payload.respond && (rsp_chan.payload.response_bytes == RSP_BYTES_WRITE))
   `ASSERT_IMPLY(a_exc_plain, clock, reset, rsp_chan.valid && rsp_chan.payload.illegal_value, rsp_chan.payload.respond && (rsp_chan.payload.response_bytes == 3'd0))

endmodule
